>>> rtl/frame_delta_run_encoder_top_macros.svh
// Assertion macros shared by the frame delta run encoder modules.
// Depends on nothing; included by the modules that carry assertions.
`ifndef FRAME_DELTA_RUN_ENCODER_TOP_MACROS_SVH
`define FRAME_DELTA_RUN_ENCODER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FDRE_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define FDRE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

>>> rtl/fdre_pkg.sv
// Shared types and constants of the frame delta run encoder.
// Used by the interfaces, the encoder, the emitter and the top level.
package fdre_pkg;

  localparam int WORD_W                  = 32;
  localparam int LEN_W                   = 21;
  localparam int COUNT_W                 = 23;
  localparam int WORD_BYTES              = 4;
  localparam int MAX_RECS                = 4;
  localparam int DEFAULT_MAX_FRAME_WORDS = 1048576;

  typedef enum logic [1:0] {
    REC_OFFSET = 2'd0,
    REC_DATA   = 2'd1,
    REC_COUNT  = 2'd2,
    REC_TOTAL  = 2'd3
  } rec_kind_e;

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_LOAD   = 1'b1
  } op_e;

  typedef struct packed {
    rec_kind_e           kind;
    logic [WORD_W-1:0]   value;
  } rec_t;

  typedef struct packed {
    logic [2:0]                count;
    rec_t [MAX_RECS-1:0]       recs;
  } rec_set_t;

endpackage

>>> rtl/fdre_if.sv
// Valid/ready channel interfaces for the input words and the output records.
// Depends on fdre_pkg for the field widths.
interface fdre_in_if;
  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic [fdre_pkg::WORD_W-1:0]  pixel_word;

  modport source (output valid, output operation, output pixel_word, input ready);
  modport sink   (input valid, input operation, input pixel_word, output ready);
endinterface

interface fdre_out_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   record_kind;
  logic [fdre_pkg::WORD_W-1:0]  record_value;
  logic                         last_of_item;

  modport source (output valid, output record_kind, output record_value,
                  output last_of_item, input ready);
  modport sink   (input valid, input record_kind, input record_value,
                  input last_of_item, output ready);
endinterface

>>> rtl/fdre_ref_mem.sv
// Reference frame memory: one write port, one read port, registered read data.
// Depends on fdre_pkg for the word width.
module fdre_ref_mem #(
  parameter int DEPTH  = fdre_pkg::DEFAULT_MAX_FRAME_WORDS,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [ADDR_W-1:0]           waddr_i,
  input  logic [fdre_pkg::WORD_W-1:0] wdata_i,
  input  logic                        re_i,
  input  logic [ADDR_W-1:0]           raddr_i,
  output logic [fdre_pkg::WORD_W-1:0] rdata_o
);

  logic [fdre_pkg::WORD_W-1:0] mem [DEPTH];
  logic [fdre_pkg::WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/fdre_emitter.sv
// Record buffer that holds the records of one item and sends them one a cycle
// while ready is high. Depends on fdre_pkg and the output channel interface.
`include "frame_delta_run_encoder_top_macros.svh"

module fdre_emitter (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  fdre_pkg::rec_set_t   set_i,
  output logic                 can_load_o,
  fdre_out_if.source           out_o
);

  logic                                         busy_q, busy_d;
  logic [2:0]                                   cnt_q, cnt_d;
  logic [1:0]                                   ptr_q, ptr_d;
  fdre_pkg::rec_t [fdre_pkg::MAX_RECS-1:0]      slots_q, slots_d;
  logic                                         last_rec;
  logic                                         hs;
  logic                                         done;

  assign last_rec   = ({1'b0, ptr_q} == (cnt_q - 3'd1));
  assign hs         = busy_q && out_o.ready;
  assign done       = hs && last_rec;
  assign can_load_o = !busy_q || done;

  assign out_o.valid        = busy_q;
  assign out_o.record_kind  = slots_q[ptr_q].kind;
  assign out_o.record_value = slots_q[ptr_q].value;
  assign out_o.last_of_item = last_rec;

  always_comb begin
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    ptr_d   = ptr_q;
    slots_d = slots_q;
    if (load_i) begin
      busy_d  = (set_i.count != 3'd0);
      cnt_d   = set_i.count;
      ptr_d   = 2'd0;
      slots_d = set_i.recs;
    end else if (hs) begin
      if (last_rec) begin
        busy_d = 1'b0;
      end else begin
        ptr_d = ptr_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 3'd0;
      ptr_q  <= 2'd0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      ptr_q  <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slots_q <= slots_d;
  end

  `FDRE_ASSERT_SAME(a_ptr_in_range, clk_i, rst_ni, busy_q, ({1'b0, ptr_q} < cnt_q))
  `FDRE_ASSERT_SAME(a_busy_has_records, clk_i, rst_ni, busy_q, (cnt_q != 3'd0))
  `FDRE_ASSERT_SAME(a_load_when_free, clk_i, rst_ni, load_i, (!busy_q || done))

endmodule

>>> rtl/fdre_encoder.sv
// Word index, reference read, compare stage and run state of the encoder.
// Depends on fdre_pkg, the input channel interface and the reference memory.
`include "frame_delta_run_encoder_top_macros.svh"

module fdre_encoder #(
  parameter int MAX_FRAME_WORDS = fdre_pkg::DEFAULT_MAX_FRAME_WORDS,
  parameter int IDX_W           = (MAX_FRAME_WORDS > 1) ? $clog2(MAX_FRAME_WORDS) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  fdre_in_if.sink                     in_i,
  input  logic [fdre_pkg::LEN_W-1:0]  cfg_len_i,
  output logic                        mem_re_o,
  output logic [IDX_W-1:0]            mem_raddr_o,
  output logic                        mem_we_o,
  output logic [IDX_W-1:0]            mem_waddr_o,
  output logic [fdre_pkg::WORD_W-1:0] mem_wdata_o,
  input  logic [fdre_pkg::WORD_W-1:0] mem_rdata_i,
  input  logic                        emit_can_load_i,
  output logic                        emit_load_o,
  output fdre_pkg::rec_set_t          rec_set_o
);

  localparam int MAXW_RAW = $clog2(MAX_FRAME_WORDS + 1);
  localparam int CMP_W    = (MAXW_RAW > fdre_pkg::LEN_W) ? MAXW_RAW : fdre_pkg::LEN_W;
  localparam int CW       = fdre_pkg::COUNT_W;

  logic [CMP_W-1:0]            len_ext;
  logic [CMP_W-1:0]            len_eff;
  logic [CMP_W-1:0]            idx_plus;
  logic                        accept;
  logic                        last_word;

  logic [IDX_W-1:0]            word_index_q, word_index_d;

  logic                        s1_valid_q, s1_valid_d;
  fdre_pkg::op_e               s1_op_q;
  logic [fdre_pkg::WORD_W-1:0] s1_word_q;
  logic [IDX_W-1:0]            s1_idx_q;
  logic                        s1_last_q;
  logic                        fwd_hit_q, fwd_hit_d;
  logic [fdre_pkg::WORD_W-1:0] fwd_data_q;
  logic                        s1_go;

  logic                        in_run_q, in_run_d;
  logic [CW-1:0]               run_bytes_q, run_bytes_d;
  logic [CW-1:0]               payload_q, payload_d;

  logic [fdre_pkg::WORD_W-1:0] ref_word;
  logic                        differ;
  fdre_pkg::rec_set_t          set_d;

  assign len_ext  = CMP_W'(cfg_len_i);
  assign len_eff  = (len_ext == '0) ? CMP_W'(1) :
                    ((len_ext > CMP_W'(MAX_FRAME_WORDS)) ? CMP_W'(MAX_FRAME_WORDS) : len_ext);
  assign idx_plus = CMP_W'(word_index_q) + CMP_W'(1);
  assign last_word = (idx_plus >= len_eff);

  assign s1_go      = s1_valid_q && emit_can_load_i;
  assign in_i.ready = !s1_valid_q || s1_go;
  assign accept     = in_i.valid && in_i.ready;

  assign word_index_d = !accept ? word_index_q :
                        (last_word ? '0 : idx_plus[IDX_W-1:0]);
  assign s1_valid_d   = accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_q);
  assign fwd_hit_d    = accept ? (s1_go && (s1_idx_q == word_index_q)) :
                        (s1_go ? 1'b0 : fwd_hit_q);

  assign mem_re_o    = accept;
  assign mem_raddr_o = word_index_q;
  assign mem_we_o    = s1_go;
  assign mem_waddr_o = s1_idx_q;
  assign mem_wdata_o = s1_word_q;

  assign emit_load_o = s1_go;
  assign rec_set_o   = set_d;

  always_comb begin
    ref_word    = fwd_hit_q ? fwd_data_q : mem_rdata_i;
    differ      = (ref_word != s1_word_q);
    set_d       = '0;
    in_run_d    = in_run_q;
    run_bytes_d = run_bytes_q;
    payload_d   = payload_q;
    if (s1_op_q == fdre_pkg::OP_ENCODE) begin
      if (differ) begin
        if (!in_run_d) begin
          set_d.recs[set_d.count[1:0]].kind  = fdre_pkg::REC_OFFSET;
          set_d.recs[set_d.count[1:0]].value = fdre_pkg::WORD_W'({s1_idx_q, 2'b00});
          set_d.count = set_d.count + 3'd1;
          in_run_d    = 1'b1;
          run_bytes_d = '0;
        end
        set_d.recs[set_d.count[1:0]].kind  = fdre_pkg::REC_DATA;
        set_d.recs[set_d.count[1:0]].value = s1_word_q;
        set_d.count = set_d.count + 3'd1;
        run_bytes_d = run_bytes_d + CW'(fdre_pkg::WORD_BYTES);
      end else if (in_run_d) begin
        set_d.recs[set_d.count[1:0]].kind  = fdre_pkg::REC_COUNT;
        set_d.recs[set_d.count[1:0]].value = fdre_pkg::WORD_W'(run_bytes_d);
        set_d.count = set_d.count + 3'd1;
        payload_d   = payload_d + CW'(2 * fdre_pkg::WORD_BYTES) + run_bytes_d;
        in_run_d    = 1'b0;
        run_bytes_d = '0;
      end
      if (s1_last_q) begin
        if (in_run_d) begin
          set_d.recs[set_d.count[1:0]].kind  = fdre_pkg::REC_COUNT;
          set_d.recs[set_d.count[1:0]].value = fdre_pkg::WORD_W'(run_bytes_d);
          set_d.count = set_d.count + 3'd1;
          payload_d   = payload_d + CW'(2 * fdre_pkg::WORD_BYTES) + run_bytes_d;
        end
        set_d.recs[set_d.count[1:0]].kind  = fdre_pkg::REC_TOTAL;
        set_d.recs[set_d.count[1:0]].value = fdre_pkg::WORD_W'(payload_d);
        set_d.count = set_d.count + 3'd1;
        in_run_d    = 1'b0;
        run_bytes_d = '0;
        payload_d   = '0;
      end
    end else if (s1_last_q) begin
      in_run_d    = 1'b0;
      run_bytes_d = '0;
      payload_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_index_q <= '0;
      s1_valid_q   <= 1'b0;
      fwd_hit_q    <= 1'b0;
      in_run_q     <= 1'b0;
      run_bytes_q  <= '0;
      payload_q    <= '0;
    end else begin
      word_index_q <= word_index_d;
      s1_valid_q   <= s1_valid_d;
      fwd_hit_q    <= fwd_hit_d;
      if (s1_go) begin
        in_run_q    <= in_run_d;
        run_bytes_q <= run_bytes_d;
        payload_q   <= payload_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q    <= fdre_pkg::op_e'(in_i.operation);
      s1_word_q  <= in_i.pixel_word;
      s1_idx_q   <= word_index_q;
      s1_last_q  <= last_word;
      fwd_data_q <= s1_word_q;
    end
  end

  `FDRE_ASSERT_SAME(a_fwd_needs_item, clk_i, rst_ni, fwd_hit_q, s1_valid_q)
  `FDRE_ASSERT_SAME(a_no_run_no_bytes, clk_i, rst_ni, !in_run_q, (run_bytes_q == '0))
  `FDRE_ASSERT_NEXT(a_frame_end_clears, clk_i, rst_ni, (s1_go && s1_last_q),
                    (!in_run_q && (payload_q == '0)))

endmodule

>>> rtl/frame_delta_run_encoder_top.sv
// Frame delta run encoder: an accepted item is registered in the compare stage, then its
// records go into the emitter's buffer. One item per cycle is taken while each item
// causes at most one record and the output is ready; more records hold the buffer longer.
// Reset clears the word index, the run state and the byte counts and sets the frame
// length to MAX_FRAME_WORDS; the reference memory keeps no reset and is undefined
// until written.
module frame_delta_run_encoder_top #(
  parameter int MAX_FRAME_WORDS = fdre_pkg::DEFAULT_MAX_FRAME_WORDS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  fdre_in_if.sink                     in_i,
  fdre_out_if.source                  out_o,
  input  logic                        cfg_we_i,
  input  logic [fdre_pkg::LEN_W-1:0]  cfg_wdata_i
);

  localparam int IDX_W = (MAX_FRAME_WORDS > 1) ? $clog2(MAX_FRAME_WORDS) : 1;

  logic [fdre_pkg::LEN_W-1:0]  cfg_len_q, cfg_len_d;
  logic                        mem_re;
  logic [IDX_W-1:0]            mem_raddr;
  logic                        mem_we;
  logic [IDX_W-1:0]            mem_waddr;
  logic [fdre_pkg::WORD_W-1:0] mem_wdata;
  logic [fdre_pkg::WORD_W-1:0] mem_rdata;
  logic                        emit_can_load;
  logic                        emit_load;
  fdre_pkg::rec_set_t          rec_set;

  assign cfg_len_d = cfg_we_i ? cfg_wdata_i : cfg_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_len_q <= fdre_pkg::LEN_W'(MAX_FRAME_WORDS);
    end else begin
      cfg_len_q <= cfg_len_d;
    end
  end

  fdre_ref_mem #(
    .DEPTH  (MAX_FRAME_WORDS),
    .ADDR_W (IDX_W)
  ) u_ref_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  fdre_encoder #(
    .MAX_FRAME_WORDS (MAX_FRAME_WORDS),
    .IDX_W           (IDX_W)
  ) u_encoder (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_i            (in_i),
    .cfg_len_i       (cfg_len_q),
    .mem_re_o        (mem_re),
    .mem_raddr_o     (mem_raddr),
    .mem_we_o        (mem_we),
    .mem_waddr_o     (mem_waddr),
    .mem_wdata_o     (mem_wdata),
    .mem_rdata_i     (mem_rdata),
    .emit_can_load_i (emit_can_load),
    .emit_load_o     (emit_load),
    .rec_set_o       (rec_set)
  );

  fdre_emitter u_emitter (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (emit_load),
    .set_i      (rec_set),
    .can_load_o (emit_can_load),
    .out_o      (out_o)
  );

endmodule

>>> verif/frame_delta_run_encoder_top_test.sv
// Self-checking testbench for frame_delta_run_encoder_top: directed rows, then random frames.
// Every record is checked against an in-bench frame delta model or its row's pinned records.
// Depends on fdre_pkg, the fdre_in_if/fdre_out_if interfaces and the encoder RTL.
module frame_delta_run_encoder_top_test;

  localparam int unsigned MAX_WORDS   = fdre_pkg::DEFAULT_MAX_FRAME_WORDS;
  localparam int          RAND_ITEMS  = 170;
  localparam int          SETTLE      = 6;
  localparam int          CYCLE_LIMIT = 400000;

  typedef struct packed {
    fdre_pkg::rec_kind_e         kind;
    logic [fdre_pkg::WORD_W-1:0] value;
    logic                        last;
  } exp_rec_t;

  typedef struct packed {
    logic                        is_cfg;
    logic [fdre_pkg::LEN_W-1:0]  len;
    fdre_pkg::op_e               op;
    logic [fdre_pkg::WORD_W-1:0] word;
    logic                        pinned;
    logic [2:0]                  n;
    fdre_pkg::rec_t [0:3]        recs;
  } row_t;

  localparam fdre_pkg::rec_t [0:3] NO_RECS    = '0;
  localparam fdre_pkg::rec_t [0:3] TOTAL_ZERO = '{'{fdre_pkg::REC_TOTAL, 32'd0}, '0, '0, '0};

  localparam row_t DIRECTED_ROWS [31] = '{
    '{1'b1, 21'd1, fdre_pkg::OP_ENCODE, 32'd0, 1'b0, 3'd0, NO_RECS},
    '{1'b0, 21'd0, fdre_pkg::OP_LOAD, 32'd0, 1'b1, 3'd0, NO_RECS},
    '{1'b0, 21'd0, fdre_pkg::OP_ENCODE, 32'd0, 1'b1, 3'd1, TOTAL_ZERO},
    '{1'b0, 21'd0, fdre_pkg::OP_ENCODE, 32'hFFFF_FFFF, 1'b1, 3'd4,
      '{'{fdre_pkg::REC_OFFSET, 32'd0}, '{fdre_pkg::REC_DATA, 32'hFFFF_FFFF},
        '{fdre_pkg::REC_COUNT, 32'd4}, '{fdre_pkg::REC_TOTAL, 32'd12}}},
    '{1'b0, 21'd0, fdre_pkg::OP_ENCODE, 32'hFFFF_FFFF, 1'b1, 3'd1, TOTAL_ZERO},
    '{1'b1, 21'd0, fdre_pkg::OP_ENCODE, 32'd0, 1'b0, 3'd0, NO_RECS},
    '{1'b0, 21'd0, fdre_pkg::OP_ENCODE, 32'd0, 1'b1, 3'd4,
      '{'{fdre_pkg::REC_OFFSET, 32'd0}, '{fdre_pkg::REC_DATA, 32'd0},
        '{fdre_pkg::REC_COUNT, 32'd4}, '{fdre_pkg::REC_TOTAL, 32'd12}}},
    '{1'b1, 21'd4, fdre_pkg::OP_ENCODE, 32'd0, 1'b0, 3'd0, NO_RECS},
    '{1'b0, 21'd0, fdre_pkg::OP_LOAD, 32'h1111_1111, 1'b0, 3'd0, NO_RECS},
    '{1'b0, 21'd0, fdre_pkg::OP_LOAD, 32'h2222_2222, 1'b0, 3'd0, NO_RECS},
    '{1'b0, 21'd0, fdre_pkg::OP_LOAD, 32'h3333_3333, 1'b0, 3'd0, NO_RECS},
    '{1'b0, 21'd0, fdre_pkg::OP_LOAD, 32'h4444_4444, 1'b0, 3'd0, NO_RECS},
    '{1'b0, 21'd0, fdre_pkg::OP_ENCODE, 32'h1111_1111, 1'b0, 3'd0, NO_RECS},
    '{1'b0, 21'd0, fdre_pkg::OP_ENCODE, 32'hDEAD_BEEF, 1'b0, 3'd0, NO_RECS},
    '{1'b0, 21'd0, fdre_pkg::OP_ENCODE, 32'hCAFE_F00D, 1'b0, 3'd0, NO_RECS},
    '{1'b0, 21'd0, fdre_pkg::OP_ENCODE, 32'h4444_4444, 1'b0, 3'd0, NO_RECS},
    '{1'b0, 21'd0, fdre_pkg::OP_ENCODE, 32'h0000_0000, 1'b0, 3'd0, NO_RECS},
    '{1'b0, 21'd0, fdre_pkg::OP_LOAD, 32'h5A5A_5A5A, 1'b0, 3'd0, NO_RECS},
    '{1'b0, 21'd0, fdre_pkg::OP_ENCODE, 32'hCAFE_F00D, 1'b0, 3'd0, NO_RECS},
    '{1'b0, 21'd0, fdre_pkg::OP_ENCODE, 32'h8000_0001, 1'b0, 3'd0, NO_RECS},
    '{1'b1, 21'(fdre_pkg::DEFAULT_MAX_FRAME_WORDS), fdre_pkg::OP_ENCODE, 32'd0,
      1'b0, 3'd0, NO_RECS},
    '{1'b0, 21'd0, fdre_pkg::OP_ENCODE, 32'h0000_0001, 1'b0, 3'd0, NO_RECS},
    '{1'b0, 21'd0, fdre_pkg::OP_ENCODE, 32'h5A5A_5A5A, 1'b0, 3'd0, NO_RECS},
    '{1'b0, 21'd0, fdre_pkg::OP_ENCODE, 32'hFFFF_FFFF, 1'b0, 3'd0, NO_RECS},
    '{1'b1, 21'd2, fdre_pkg::OP_ENCODE, 32'd0, 1'b0, 3'd0, NO_RECS},
    '{1'b0, 21'd0, fdre_pkg::OP_ENCODE, 32'h8000_0001, 1'b0, 3'd0, NO_RECS},
    '{1'b1, 21'h1F_FFFF, fdre_pkg::OP_ENCODE, 32'd0, 1'b0, 3'd0, NO_RECS},
    '{1'b0, 21'd0, fdre_pkg::OP_ENCODE, 32'h7FFF_FFFE, 1'b0, 3'd0, NO_RECS},
    '{1'b0, 21'd0, fdre_pkg::OP_ENCODE, 32'h1234_5678, 1'b0, 3'd0, NO_RECS},
    '{1'b1, 21'd3, fdre_pkg::OP_ENCODE, 32'd0, 1'b0, 3'd0, NO_RECS},
    '{1'b0, 21'd0, fdre_pkg::OP_ENCODE, 32'h0000_0000, 1'b0, 3'd0, NO_RECS}
  };

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_we;
  logic [fdre_pkg::LEN_W-1:0] cfg_wdata;

  fdre_in_if  in_if ();
  fdre_out_if out_if ();

  frame_delta_run_encoder_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  // Model state of the encoder.
  logic [fdre_pkg::WORD_W-1:0]  ref_words [int unsigned];
  logic [fdre_pkg::LEN_W-1:0]   frame_len;
  int unsigned                  word_idx;
  bit                           in_run;
  logic [fdre_pkg::COUNT_W-1:0] run_bytes;
  logic [fdre_pkg::COUNT_W-1:0] payload_bytes;

  exp_rec_t exp_q [$];
  exp_rec_t step_recs [$];
  exp_rec_t head;

  int  errors;
  int  rec_seen;
  int  cycles;
  bit  tx_quiet;
  bit  rx_quiet;
  bit  stress_on;
  bit  long_hold_done;
  int  rx_hold;
  int  rx_cycles;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("frame_delta_run_encoder_top: mismatch");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 11) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic report_error(input string what, input logic [31:0] got,
                              input logic [31:0] want);
    $display("ERROR: record %0d %s: got %h, want %h", rec_seen, what, got, want);
    errors++;
  endtask

  task automatic add_rec(input fdre_pkg::rec_kind_e kind, input logic [31:0] value);
    step_recs.push_back('{kind, value, 1'b0});
  endtask

  task automatic close_run_rec();
    add_rec(fdre_pkg::REC_COUNT, 32'(run_bytes));
    payload_bytes = payload_bytes + fdre_pkg::COUNT_W'(2 * fdre_pkg::WORD_BYTES) + run_bytes;
    in_run = 1'b0;
    run_bytes = '0;
  endtask

  task automatic predict_records(input fdre_pkg::op_e op,
                                 input logic [fdre_pkg::WORD_W-1:0] word);
    int unsigned len;
    int unsigned idx;
    bit          at_last;
    exp_rec_t    tail;
    len = (frame_len == 0) ? 1 : ((frame_len > MAX_WORDS) ? MAX_WORDS : frame_len);
    idx = word_idx;
    at_last = (idx + 1 >= len);
    if (idx >= MAX_WORDS) idx = 0;
    step_recs.delete();
    if (op == fdre_pkg::OP_LOAD) begin
      ref_words[idx] = word;
    end else begin
      if (ref_words[idx] != word) begin
        ref_words[idx] = word;
        if (!in_run) begin
          add_rec(fdre_pkg::REC_OFFSET, idx * fdre_pkg::WORD_BYTES);
          in_run = 1'b1;
          run_bytes = '0;
        end
        add_rec(fdre_pkg::REC_DATA, word);
        run_bytes = run_bytes + fdre_pkg::COUNT_W'(fdre_pkg::WORD_BYTES);
      end else if (in_run) begin
        close_run_rec();
      end
      if (at_last) begin
        if (in_run) close_run_rec();
        add_rec(fdre_pkg::REC_TOTAL, 32'(payload_bytes));
      end
    end
    if (at_last) begin
      word_idx = 0;
      in_run = 1'b0;
      run_bytes = '0;
      payload_bytes = '0;
    end else begin
      word_idx = idx + 1;
    end
    if (step_recs.size() > 0) begin
      tail = step_recs.pop_back();
      tail.last = 1'b1;
      step_recs.push_back(tail);
    end
  endtask

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_item(input fdre_pkg::op_e op, input logic [fdre_pkg::WORD_W-1:0] word,
                           input bit pinned, input logic [2:0] pin_n,
                           input fdre_pkg::rec_t [0:3] pin_recs);
    int gap;
    gap = tx_quiet ? 0 : gap_len();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.operation  <= op;
    in_if.pixel_word <= word;
    do @(posedge clk_i); while (!in_if.ready);
    predict_records(op, word);
    if (pinned) begin
      for (int k = 0; k < int'(pin_n); k++) begin
        exp_q.push_back('{pin_recs[k].kind, pin_recs[k].value, k == int'(pin_n) - 1});
      end
    end else begin
      foreach (step_recs[k]) exp_q.push_back(step_recs[k]);
    end
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (exp_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_frame_len(input logic [fdre_pkg::LEN_W-1:0] len);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    frame_len = len;
  endtask

  initial begin
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_hold > 0) begin
        out_if.ready <= 1'b0;
        rx_hold--;
      end else begin
        out_if.ready <= 1'b1;
        if (stress_on && !long_hold_done) begin
          long_hold_done = 1'b1;
          rx_hold = 150;
        end else if (!rx_quiet) begin
          rx_hold = gap_len();
        end
      end
      rx_cycles++;
      if (rx_cycles % 64 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      rec_seen++;
      if (exp_q.size() == 0) begin
        report_error("record with nothing expected", out_if.record_value, 32'd0);
      end else begin
        head = exp_q.pop_front();
        if (out_if.record_kind !== head.kind)
          report_error("record_kind", 32'(out_if.record_kind), 32'(head.kind));
        if (out_if.record_value !== head.value)
          report_error("record_value", out_if.record_value, head.value);
        if (out_if.last_of_item !== head.last)
          report_error("last_of_item", 32'(out_if.last_of_item), 32'(head.last));
      end
    end
  end

  initial begin
    row_t                        row;
    int                          rand_items;
    int                          phase_items;
    int                          pick;
    fdre_pkg::op_e               op;
    logic [fdre_pkg::WORD_W-1:0] word;
    logic [fdre_pkg::LEN_W-1:0]  len;

    rst_ni           = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    in_if.valid      = 1'b0;
    in_if.operation  = fdre_pkg::OP_ENCODE;
    in_if.pixel_word = '0;
    frame_len        = fdre_pkg::LEN_W'(fdre_pkg::DEFAULT_MAX_FRAME_WORDS);
    word_idx         = 0;
    in_run           = 1'b0;
    run_bytes        = '0;
    payload_bytes    = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (DIRECTED_ROWS[i]) begin
      row = DIRECTED_ROWS[i];
      if (row.is_cfg) write_frame_len(row.len);
      else send_item(row.op, row.word, row.pinned, row.n, row.recs);
    end

    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) len = '0;
      else if (pick == 1) len = fdre_pkg::LEN_W'(1);
      else if (pick == 2) len = fdre_pkg::LEN_W'(fdre_pkg::DEFAULT_MAX_FRAME_WORDS);
      else if (pick == 3) len = '1;
      else if (pick < 10) len = fdre_pkg::LEN_W'($urandom_range(2, 6));
      else len = fdre_pkg::LEN_W'($urandom_range(7, 24));
      write_frame_len(len);
      stress_on = 1'b1;
      tx_quiet = ($urandom_range(0, 3) == 0);
      phase_items = $urandom_range(6, 24);
      repeat (phase_items) begin
        // Entries never written are loaded first so that no compare reads them.
        if (!ref_words.exists(word_idx)) begin
          op = fdre_pkg::OP_LOAD;
          word = $urandom;
        end else begin
          op = ($urandom_range(0, 9) == 0) ? fdre_pkg::OP_LOAD : fdre_pkg::OP_ENCODE;
          pick = $urandom_range(0, 9);
          if (pick < 4) word = ref_words[word_idx];
          else if (pick == 4) word = '0;
          else if (pick == 5) word = '1;
          else word = $urandom;
        end
        send_item(op, word, 1'b0, 3'd0, NO_RECS);
        rand_items++;
      end
    end

    wait_idle();
    if (errors == 0) begin
      $display("frame_delta_run_encoder_top: match");
    end else begin
      $display("frame_delta_run_encoder_top: mismatch");
    end
    $finish;
  end

endmodule
